// File: src/oal_pkg.sv
// Shared constants, types and codes for the ordered array list.
`timescale 1ns / 1ps
package oal_pkg;

	// Number of entries the list can hold.
	localparam int CAPACITY = 16;

	// Widths of stored and port fields.
	localparam int KEY_W   = 16;
	localparam int PAY_W   = 32;
	localparam int ENTRY_W = KEY_W + PAY_W;
	localparam int CMD_W   = 2;
	localparam int POS_W   = 5;
	localparam int STAT_W  = 3;
	localparam int FIDX_W  = 4;
	localparam int FCNT_W  = 5;

	// Internal widths that follow from the capacity.
	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

	typedef enum logic [CMD_W-1:0] {
		CMD_APPEND = 2'd0,
		CMD_INSERT = 2'd1,
		CMD_SEARCH = 2'd2,
		CMD_DELETE = 2'd3
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK       = 3'd0,
		ST_FULL     = 3'd1,
		ST_BADPOS   = 3'd2,
		ST_EMPTY    = 3'd3,
		ST_NOTFOUND = 3'd4
	} status_t;

endpackage

// File: src/oal_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
module oal_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                       wr_data,
	input  logic                                   rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                       rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// File: src/ordered_array_list.sv
// Ordered array list: bounded list of key and payload entries kept in one RAM.
// Flow: append, error results and inserts or deletes that move nothing go
// straight from the request to the result state; an insert or delete that moves k entries,
// or a search that reads k entries, first walks them in the move state (k is at most CAPACITY,
// and a search stops at a match). Throughput: one request at a time, set by the single RAM read port that
// walks the entries one per cycle. Async active-low reset empties the list.
`timescale 1ns / 1ps
module ordered_array_list import oal_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [CMD_W-1:0]   cmd,
	input  logic [KEY_W-1:0]   entry_key,
	input  logic [PAY_W-1:0]   entry_payload,
	input  logic [POS_W-1:0]   position,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [STAT_W-1:0]  status,
	output logic [FIDX_W-1:0]  found_index,
	output logic [FCNT_W-1:0]  entry_count
);

	// The controller idles until a request arrives, walks the RAM in the
	// move state when entries must shift or be scanned, and then parks the
	// result in the result state until the output register is free.
	typedef enum logic [1:0] {
		S_IDLE,
		S_MOVE,
		S_RESULT
	} state_t;

	state_t             state_q;
	cmd_t               cmd_q;
	logic [KEY_W-1:0]   key_q;
	logic [PAY_W-1:0]   pay_q;
	logic [IDX_W-1:0]   pos_q;
	logic [CNT_W-1:0]   fill_q;
	logic [IDX_W-1:0]   src_q;
	logic [CNT_W-1:0]   rem_q;
	logic               rv_s1;
	logic [IDX_W-1:0]   addr_s1;
	status_t            res_status_q;
	logic [IDX_W-1:0]   res_index_q;
	logic               out_valid_q;
	status_t            status_q;
	logic [FIDX_W-1:0]  found_index_q;
	logic [FCNT_W-1:0]  entry_count_q;

	// RAM port signals.
	logic               wr_en;
	logic [IDX_W-1:0]   wr_addr;
	logic [ENTRY_W-1:0] wr_data;
	logic               rd_en;
	logic [ENTRY_W-1:0] rd_data;

	// Request decode.
	logic               accept;
	cmd_t               in_cmd;
	logic [CMP_W-1:0]   n_c;
	logic [CMP_W-1:0]   p_c;
	logic [IDX_W-1:0]   pos_idx;
	logic [CNT_W-1:0]   pos_cnt;
	logic [IDX_W-1:0]   fill_idx;
	logic               full_c;
	logic               empty_c;
	status_t            acc_status;
	logic               acc_scan;
	logic               acc_wr;
	logic [IDX_W-1:0]   acc_wr_addr;
	logic [IDX_W-1:0]   acc_src;
	logic [CNT_W-1:0]   acc_rem;
	logic [CNT_W-1:0]   acc_fill;

	// Walk control.
	logic [KEY_W-1:0]   rd_key;
	logic               hit;
	logic               shift_wr;
	logic [IDX_W-1:0]   shift_addr;
	logic               move_done;
	logic               final_wr;

	// Zero-extended copies used to fit the index and count to the port widths.
	logic [IDX_W+FIDX_W-1:0] idx_wide;
	logic [CNT_W+FCNT_W-1:0] cnt_wide;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign in_cmd   = cmd_t'(cmd);

	assign n_c      = CMP_W'(fill_q);
	assign p_c      = CMP_W'(position);
	assign pos_idx  = IDX_W'(position);
	assign pos_cnt  = CNT_W'(position);
	assign fill_idx = IDX_W'(fill_q);
	assign full_c   = (fill_q == CNT_W'(CAPACITY));
	assign empty_c  = (fill_q == '0);

	// Classify the incoming request. Errors and the moves-free cases finish
	// right away; the rest set up a walk of the RAM: inserts walk downward
	// from the last entry, deletes and searches walk upward.
	always_comb begin
		acc_status  = ST_OK;
		acc_scan    = 1'b0;
		acc_wr      = 1'b0;
		acc_wr_addr = fill_idx;
		acc_src     = '0;
		acc_rem     = '0;
		acc_fill    = fill_q;
		case (in_cmd)
			CMD_APPEND: begin
				if (full_c) begin
					acc_status = ST_FULL;
				end else begin
					acc_wr   = 1'b1;
					acc_fill = fill_q + 1'b1;
				end
			end
			CMD_INSERT: begin
				if (full_c) begin
					acc_status = ST_FULL;
				end else if (p_c > n_c) begin
					acc_status = ST_BADPOS;
				end else begin
					acc_fill = fill_q + 1'b1;
					if (p_c == n_c) begin
						acc_wr      = 1'b1;
						acc_wr_addr = pos_idx;
					end else begin
						acc_scan = 1'b1;
						acc_src  = IDX_W'(fill_q - 1'b1);
						acc_rem  = fill_q - pos_cnt;
					end
				end
			end
			CMD_SEARCH: begin
				if (empty_c) begin
					acc_status = ST_EMPTY;
				end else begin
					acc_scan = 1'b1;
					acc_rem  = fill_q;
				end
			end
			CMD_DELETE: begin
				if (empty_c) begin
					acc_status = ST_EMPTY;
				end else if (p_c >= n_c) begin
					acc_status = ST_BADPOS;
				end else begin
					acc_fill = fill_q - 1'b1;
					if (p_c != n_c - 1'b1) begin
						acc_scan = 1'b1;
						acc_src  = pos_idx + 1'b1;
						acc_rem  = fill_q - 1'b1 - pos_cnt;
					end
				end
			end
			default: begin
				acc_status = ST_OK;
			end
		endcase
	end

	// One read is issued per cycle during the walk. The data comes back in the
	// next cycle and is written one slot up (insert) or one slot down
	// (delete); that write never lands on the address being read.
	assign rd_en      = (state_q == S_MOVE) && (rem_q != '0);
	assign rd_key     = rd_data[ENTRY_W-1 -: KEY_W];
	assign hit        = (state_q == S_MOVE) && rv_s1 && (cmd_q == CMD_SEARCH)
	                    && (rd_key == key_q);
	assign shift_wr   = (state_q == S_MOVE) && rv_s1 && (cmd_q != CMD_SEARCH);
	assign shift_addr = (cmd_q == CMD_INSERT) ? (addr_s1 + 1'b1) : (addr_s1 - 1'b1);
	assign move_done  = (state_q == S_MOVE) && (rem_q == '0) && !rv_s1;
	assign final_wr   = move_done && (cmd_q == CMD_INSERT);

	// Write port: a direct store at request time, a shifted entry during
	// the walk, or the new entry once an insert has opened its gap.
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = acc_wr_addr;
		wr_data = {entry_key, entry_payload};
		if (accept && acc_wr) begin
			wr_en = 1'b1;
		end else if (shift_wr) begin
			wr_en   = 1'b1;
			wr_addr = shift_addr;
			wr_data = rd_data;
		end else if (final_wr) begin
			wr_en   = 1'b1;
			wr_addr = pos_q;
			wr_data = {key_q, pay_q};
		end
	end

	oal_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (CAPACITY)
	) u_entry_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (src_q),
		.rd_data (rd_data)
	);

	assign idx_wide = {{FIDX_W{1'b0}}, res_index_q};
	assign cnt_wide = {{FCNT_W{1'b0}}, fill_q};

	// Controller and output register. The fill count is updated when the
	// request is accepted, so the result reports the count after the command.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			cmd_q         <= CMD_APPEND;
			key_q         <= '0;
			pay_q         <= '0;
			pos_q         <= '0;
			fill_q        <= '0;
			src_q         <= '0;
			rem_q         <= '0;
			rv_s1         <= 1'b0;
			addr_s1       <= '0;
			res_status_q  <= ST_OK;
			res_index_q   <= '0;
			out_valid_q   <= 1'b0;
			status_q      <= ST_OK;
			found_index_q <= '0;
			entry_count_q <= '0;
		end else begin
			rv_s1   <= rd_en;
			addr_s1 <= src_q;
			// In the result state the output register is reloaded below instead.
			if (out_valid_q && out_ready && (state_q != S_RESULT)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						cmd_q        <= in_cmd;
						key_q        <= entry_key;
						pay_q        <= entry_payload;
						pos_q        <= pos_idx;
						fill_q       <= acc_fill;
						src_q        <= acc_src;
						rem_q        <= acc_rem;
						res_status_q <= acc_status;
						res_index_q  <= '0;
						state_q      <= acc_scan ? S_MOVE : S_RESULT;
					end
				end
				S_MOVE: begin
					if (rd_en) begin
						rem_q <= rem_q - 1'b1;
						src_q <= (cmd_q == CMD_INSERT) ? (src_q - 1'b1) : (src_q + 1'b1);
					end
					if (hit) begin
						res_status_q <= ST_OK;
						res_index_q  <= addr_s1;
						state_q      <= S_RESULT;
					end else if (move_done) begin
						res_status_q <= (cmd_q == CMD_SEARCH) ? ST_NOTFOUND : ST_OK;
						state_q      <= S_RESULT;
					end
				end
				S_RESULT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q   <= 1'b1;
						status_q      <= res_status_q;
						found_index_q <= idx_wide[FIDX_W-1:0];
						entry_count_q <= cnt_wide[FCNT_W-1:0];
						state_q       <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign found_index = found_index_q;
	assign entry_count = entry_count_q;

`ifndef SYNTH
	// The list never holds more entries than it has room for.
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(CAPACITY))
		else $error("fill count exceeds capacity");

	// A shifted write must never hit the entry being read in the same cycle.
	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_en && wr_en) |-> (wr_addr != src_q))
		else $error("RAM read and write collide on one entry");

	// An accepted request always leaves the idle state.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !in_ready)
		else $error("request accepted but controller stayed idle");

	// Reads are issued only while walking the list.
	a_read_in_move: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> (state_q == S_MOVE))
		else $error("RAM read outside of a walk");
`endif

endmodule
